// ===== hw/rtl/pteb_pkg.sv =====
// Shared constants, types and helper functions for the pixel-to-bearing pipeline
`timescale 1ns / 1ps

package pteb_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    typedef logic [31:0]        turn_t;
    typedef logic signed [31:0] q30_t;

    typedef enum logic [1:0] {
        REG_FRAME_W = 2'd0,
        REG_FRAME_H = 2'd1,
        REG_FOV_X   = 2'd2,
        REG_FOV_Y   = 2'd3
    } reg_idx_t;

    localparam logic signed [31:0] INV_GAIN     = 32'sd652032874;
    localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;

    localparam logic [12:0] DIM_MIN = 13'd100;
    localparam logic [12:0] DIM_MAX = 13'd8000;
    localparam logic [13:0] FOV_MIN = 14'd1000;
    localparam logic [13:0] FOV_MAX = 14'd15000;

    localparam logic [12:0] DIM_RESET = 13'd360;
    localparam logic [13:0] FOV_RESET = 14'd6000;

    // turns per unit with 27 fraction bits: 2^59 / full scale
    localparam int          TURN_FRAC   = 27;
    localparam logic [63:0] TURN_K_CD   = (64'd1 << 59) / 64'd36000;
    localparam logic [63:0] TURN_K_FOV  = (64'd1 << 59) / 64'd72000;

    localparam logic signed [16:0] CD_PER_TURN = 17'sd36000;
    localparam logic signed [16:0] CD_HALF     = 17'sd18000;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051D;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2E;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517C;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A2F;
            19: t = 32'h00000517;
            20: t = 32'h0000028B;
            21: t = 32'h00000145;
            22: t = 32'h000000A2;
            23: t = 32'h00000051;
            24: t = 32'h00000028;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000002;
            29: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // p / 2^k rounded half away from zero
    function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] p, input int k);
        logic        neg;
        logic [67:0] m;
        neg = p[67];
        m   = neg ? 68'(-p) : 68'(p);
        m   = (m + (68'd1 << (k - 1))) >> k;
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== hw/rtl/pteb_delay.sv =====
// Fixed-depth register delay line
`timescale 1ns / 1ps

module pteb_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// ===== hw/rtl/pteb_cordic_cell.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring mode
`timescale 1ns / 1ps

module pteb_cordic_cell #(
    parameter int XW     = 32,
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0,
    parameter int TW     = 1
) (
    input  logic                 clk,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [33:0]   z_in,
    input  logic [TW-1:0]        tag_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [33:0]   z_out,
    output logic [TW-1:0]        tag_out
);

    localparam logic signed [33:0] ANG_STEP = $signed({2'b00, pteb_pkg::atan_turn(STAGE)});

    logic signed [XW-1:0] dx, dy, x_next, y_next;
    logic signed [33:0]   z_next;
    logic                 step_pos;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [33:0]   z_reg;
    logic [TW-1:0]        tag_reg;

    always_comb
    begin
        dx       = x_in >>> STAGE;
        dy       = y_in >>> STAGE;
        // rotation drives z to zero, vectoring drives y to zero
        step_pos = VECTOR ? y_in[XW-1] : ~z_in[33];
        if (step_pos)
        begin
            x_next = x_in - dy;
            y_next = y_in + dx;
            z_next = z_in - ANG_STEP;
        end
        else
        begin
            x_next = x_in + dy;
            y_next = y_in - dx;
            z_next = z_in + ANG_STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        tag_reg <= tag_in;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

// ===== hw/rtl/pteb_sincos.sv =====
// Pipelined CORDIC sine/cosine, Q30 outputs
`timescale 1ns / 1ps

module pteb_sincos #(
    parameter int STAGES = pteb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  pteb_pkg::turn_t     ang,
    output pteb_pkg::q30_t      sin_out,
    output pteb_pkg::q30_t      cos_out
);

    logic signed [31:0] xs [STAGES+1];
    logic signed [31:0] ys [STAGES+1];
    logic signed [33:0] zs [STAGES+1];
    logic [0:0]         ts [STAGES+1];

    logic [31:0] probe, ang_fold;
    logic        flip;
    pteb_pkg::q30_t sin_reg, cos_reg;

    // fold the left half plane onto the right one
    always_comb
    begin
        probe    = ang + pteb_pkg::QUARTER_TURN;
        flip     = probe[31];
        ang_fold = flip ? ang - pteb_pkg::HALF_TURN : ang;
    end

    assign xs[0] = pteb_pkg::INV_GAIN;
    assign ys[0] = 32'sd0;
    assign zs[0] = 34'($signed(ang_fold));
    assign ts[0] = flip;

    for (genvar i = 0; i < STAGES; i++)
    begin : gen_cell
        pteb_cordic_cell #(
            .XW     (32),
            .STAGE  (i),
            .VECTOR (1'b0),
            .TW     (1)
        ) u_cell (
            .clk     (clk),
            .x_in    (xs[i]),
            .y_in    (ys[i]),
            .z_in    (zs[i]),
            .tag_in  (ts[i]),
            .x_out   (xs[i+1]),
            .y_out   (ys[i+1]),
            .z_out   (zs[i+1]),
            .tag_out (ts[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= ts[STAGES][0] ? -ys[STAGES] : ys[STAGES];
        cos_reg <= ts[STAGES][0] ? -xs[STAGES] : xs[STAGES];
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== hw/rtl/pteb_atan2.sv =====
// Pipelined CORDIC atan2 in turns with gain-scaled magnitude
`timescale 1ns / 1ps

module pteb_atan2 #(
    parameter int STAGES = pteb_pkg::CORDIC_STAGES_DEF,
    parameter int IW     = 34
) (
    input  logic                 clk,
    input  logic signed [IW-1:0] x_in,
    input  logic signed [IW-1:0] y_in,
    output pteb_pkg::turn_t      turn_out,
    output logic signed [IW+1:0] mag_out
);

    localparam int XW = IW + 2;

    logic signed [XW-1:0] xs [STAGES+1];
    logic signed [XW-1:0] ys [STAGES+1];
    logic signed [33:0]   zs [STAGES+1];
    logic [0:0]           ts [STAGES+1];

    logic                 is_zero, x_neg;
    logic signed [XW-1:0] x_ext, y_ext;
    pteb_pkg::turn_t      turn_reg;
    logic signed [XW-1:0] mag_reg;

    always_comb
    begin
        is_zero = (x_in == '0) && (y_in == '0);
        x_neg   = x_in[IW-1];
        x_ext   = XW'(x_in);
        y_ext   = XW'(y_in);
    end

    assign xs[0] = x_neg ? -x_ext : x_ext;
    assign ys[0] = x_neg ? -y_ext : y_ext;
    assign zs[0] = x_neg ? $signed({2'b00, pteb_pkg::HALF_TURN}) : 34'sd0;
    assign ts[0] = is_zero;

    for (genvar i = 0; i < STAGES; i++)
    begin : gen_cell
        pteb_cordic_cell #(
            .XW     (XW),
            .STAGE  (i),
            .VECTOR (1'b1),
            .TW     (1)
        ) u_cell (
            .clk     (clk),
            .x_in    (xs[i]),
            .y_in    (ys[i]),
            .z_in    (zs[i]),
            .tag_in  (ts[i]),
            .x_out   (xs[i+1]),
            .y_out   (ys[i+1]),
            .z_out   (zs[i+1]),
            .tag_out (ts[i+1])
        );
    end

    // angle wraps modulo one turn
    always_ff @(posedge clk)
    begin
        turn_reg <= ts[STAGES][0] ? '0 : zs[STAGES][31:0];
        mag_reg  <= ts[STAGES][0] ? '0 : xs[STAGES];
    end

    assign turn_out = turn_reg;
    assign mag_out  = mag_reg;

endmodule

// ===== hw/rtl/pixel_to_earth_bearing_top.sv =====
// Pixel offset plus gimbal/vehicle attitude to earth-frame yaw and pitch bearing
//
// Usage:
//  - Configure frame size and field of view over the APB port (byte addresses
//    0x0 width, 0x4 height, 0x8 horizontal FOV, 0xC vertical FOV) while idle.
//  - Pulse start with a detection on pix_x/pix_y and the five attitude angles.
//    busy is always low: a new transaction is taken on every clock cycle.
//  - done is high for one cycle with bearing_yaw/bearing_pitch in centidegrees.
//  - The pipeline holds three CORDIC chains in series: the seven parallel
//    sine/cosine chains, then the two atan2 chains; each chain is
//    CORDIC_STAGES cells plus one output register.
//  - Results follow input order, one per transaction; the receiver cannot
//    stall, so nothing is held back.
//  - Reset clears the pipeline valid bits and restores width/height 360 and
//    FOV 60.00 degrees.
`timescale 1ns / 1ps

module pixel_to_earth_bearing_top #(
    parameter int CORDIC_STAGES = pteb_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [13:0] pix_x,
    input  logic signed [13:0] pix_y,
    input  logic signed [15:0] gimbal_roll,
    input  logic signed [15:0] gimbal_pitch,
    input  logic signed [15:0] gimbal_yaw,
    input  logic signed [15:0] vehicle_roll,
    input  logic signed [15:0] vehicle_pitch,
    output logic               done,
    output logic signed [15:0] bearing_yaw,
    output logic signed [15:0] bearing_pitch
);

    localparam int L = CORDIC_STAGES;

    // rotation order: gimbal roll, pitch, yaw, then -vehicle pitch, -vehicle roll
    localparam int ROT_ANGLE [5] = '{2, 3, 4, 6, 5};
    localparam int ROT_P     [5] = '{1, 2, 0, 2, 1};
    localparam int ROT_Q     [5] = '{2, 0, 1, 0, 2};
    localparam int ROT_O     [5] = '{0, 1, 2, 1, 0};

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        return (v < pteb_pkg::DIM_MIN) ? pteb_pkg::DIM_MIN :
               (v > pteb_pkg::DIM_MAX) ? pteb_pkg::DIM_MAX : v;
    endfunction

    function automatic logic [13:0] clamp_fov(input logic [13:0] v);
        return (v < pteb_pkg::FOV_MIN) ? pteb_pkg::FOV_MIN :
               (v > pteb_pkg::FOV_MAX) ? pteb_pkg::FOV_MAX : v;
    endfunction

    function automatic logic signed [13:0] clamp_pix(input logic signed [13:0] p,
                                                     input logic [12:0] lim);
        logic signed [14:0] p_ext, l_pos;
        p_ext = 15'(p);
        l_pos = $signed({2'b00, lim});
        if (p_ext > l_pos)
        begin
            p_ext = l_pos;
        end
        else if (p_ext < -l_pos)
        begin
            p_ext = -l_pos;
        end
        return p_ext[13:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [12:0] width_reg, height_reg;
    logic [13:0] fovx_reg, fovy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pteb_pkg::DIM_RESET;
            height_reg <= pteb_pkg::DIM_RESET;
            fovx_reg   <= pteb_pkg::FOV_RESET;
            fovy_reg   <= pteb_pkg::FOV_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (pteb_pkg::reg_idx_t'(paddr[3:2]))
                pteb_pkg::REG_FRAME_W: width_reg  <= pwdata[12:0];
                pteb_pkg::REG_FRAME_H: height_reg <= pwdata[12:0];
                pteb_pkg::REG_FOV_X:   fovx_reg   <= pwdata[13:0];
                pteb_pkg::REG_FOV_Y:   fovy_reg   <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (pteb_pkg::reg_idx_t'(paddr[3:2]))
            pteb_pkg::REG_FRAME_W: prdata = {19'd0, width_reg};
            pteb_pkg::REG_FRAME_H: prdata = {19'd0, height_reg};
            pteb_pkg::REG_FOV_X:   prdata = {18'd0, fovx_reg};
            pteb_pkg::REG_FOV_Y:   prdata = {18'd0, fovy_reg};
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- stage 1: clamp and capture ----------------
    logic               v_s1;
    logic [12:0]        w_s1, h_s1;
    logic [13:0]        fx_s1, fy_s1;
    logic signed [13:0] px_s1, py_s1;
    logic signed [15:0] ang_s1 [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1 <= 1'b0;
        end
        else
        begin
            v_s1 <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        w_s1      <= clamp_dim(width_reg);
        h_s1      <= clamp_dim(height_reg);
        fx_s1     <= clamp_fov(fovx_reg);
        fy_s1     <= clamp_fov(fovy_reg);
        px_s1     <= clamp_pix(pix_x, clamp_dim(width_reg));
        py_s1     <= clamp_pix(pix_y, clamp_dim(height_reg));
        ang_s1[0] <= gimbal_roll;
        ang_s1[1] <= gimbal_pitch;
        ang_s1[2] <= gimbal_yaw;
        ang_s1[3] <= vehicle_roll;
        ang_s1[4] <= vehicle_pitch;
    end

    // ---------------- stage 2: angle to turns partial products ----------------
    // angle slots: 0 fov x half, 1 fov y half, 2..4 gimbal, 5 vehicle roll, 6 vehicle pitch
    logic               v_s2;
    logic [37:0]        plo_s2 [7];
    logic [37:0]        phi_s2 [7];
    logic               neg_s2 [7];
    logic [25:0]        a_s2;
    logic signed [27:0] bx_s2, cw_s2;

    logic [15:0] ang_mag [7];
    logic        ang_neg [7];
    logic [63:0] ang_k   [7];

    always_comb
    begin
        ang_mag[0] = {2'b00, fx_s1};
        ang_mag[1] = {2'b00, fy_s1};
        ang_neg[0] = 1'b0;
        ang_neg[1] = 1'b0;
        ang_k[0]   = pteb_pkg::TURN_K_FOV;
        ang_k[1]   = pteb_pkg::TURN_K_FOV;
        for (int k = 2; k < 7; k++)
        begin
            ang_mag[k] = ang_s1[k-2][15] ? 16'(-ang_s1[k-2]) : 16'(ang_s1[k-2]);
            ang_k[k]   = pteb_pkg::TURN_K_CD;
            // vehicle angles enter negated
            ang_neg[k] = (k >= 5) ? (!ang_s1[k-2][15] && (ang_s1[k-2] != 16'sd0))
                                  : ang_s1[k-2][15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s2 <= 1'b0;
        end
        else
        begin
            v_s2 <= v_s1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 7; k++)
        begin
            plo_s2[k] <= ang_mag[k] * ang_k[k][21:0];
            phi_s2[k] <= ang_mag[k] * ang_k[k][43:22];
            neg_s2[k] <= ang_neg[k];
        end
        a_s2  <= w_s1 * h_s1;
        bx_s2 <= px_s1 * $signed({1'b0, h_s1});
        cw_s2 <= py_s1 * $signed({1'b0, w_s1});
    end

    // ---------------- stage 3: round to turns, normalize shift ----------------
    logic               v_s3;
    pteb_pkg::turn_t    turn_s3 [7];
    logic [25:0]        a_s3;
    logic signed [27:0] bx_s3, cw_s3;
    logic [3:0]         sh_s3;

    logic [59:0] turn_full [7];
    logic [4:0]  a_msb;

    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            turn_full[k] = ({22'd0, phi_s2[k]} << 22) + 60'(plo_s2[k])
                           + (60'd1 << (pteb_pkg::TURN_FRAC - 1));
        end
        a_msb = '0;
        for (int i = 0; i < 26; i++)
        begin
            if (a_s2[i])
            begin
                a_msb = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s3 <= 1'b0;
        end
        else
        begin
            v_s3 <= v_s2;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 7; k++)
        begin
            turn_s3[k] <= neg_s2[k] ? 32'd0 - turn_full[k][58:27] : turn_full[k][58:27];
        end
        a_s3  <= a_s2;
        bx_s3 <= bx_s2;
        cw_s3 <= cw_s2;
        // brings w*h into [2^28, 2^29)
        sh_s3 <= 4'(5'd28 - a_msb);
    end

    // scaled direction terms, delayed alongside the trig chains
    logic [28:0]        a_shift;
    logic signed [30:0] b_shift, c_shift;

    always_comb
    begin
        a_shift = 29'(a_s3) << sh_s3;
        b_shift = 31'(bx_s3) <<< (5'(sh_s3) + 5'd1);
        c_shift = 31'(cw_s3) <<< (5'(sh_s3) + 5'd1);
    end

    logic [91:0]        abc_d;
    logic               v_t0;
    logic signed [29:0] a_d;
    logic signed [30:0] b_d, c_d;

    pteb_delay #(.W(92), .DEPTH(L + 1)) u_dly_abc (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({1'b0, a_shift, b_shift, c_shift}),
        .q     (abc_d)
    );

    pteb_delay #(.W(1), .DEPTH(L + 1)) u_dly_v0 (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (v_s3),
        .q     (v_t0)
    );

    assign a_d = $signed(abc_d[91:62]);
    assign b_d = $signed(abc_d[61:31]);
    assign c_d = $signed(abc_d[30:0]);

    // ---------------- sine/cosine of all seven angles ----------------
    pteb_pkg::q30_t sn [7];
    pteb_pkg::q30_t cs [7];

    for (genvar k = 0; k < 7; k++)
    begin : gen_sc
        pteb_sincos #(.STAGES(L)) u_sincos (
            .clk     (clk),
            .ang     (turn_s3[k]),
            .sin_out (sn[k]),
            .cos_out (cs[k])
        );
    end

    // ---------------- camera-frame direction ----------------
    logic               v_m1, v_m2, v_m3, v_m4;
    logic signed [63:0] pa_m1, pb_m1, pc_m1;
    logic signed [63:0] r0_m3, r1_m3, r2_m3;
    logic signed [31:0] q0_m2, q1_m2, q2_m2;
    pteb_pkg::q30_t     cx_m1, cy_m1, cx_m2, cy_m2;
    logic signed [31:0] rv_reg [6][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_m1 <= 1'b0;
            v_m2 <= 1'b0;
            v_m3 <= 1'b0;
            v_m4 <= 1'b0;
        end
        else
        begin
            v_m1 <= v_t0;
            v_m2 <= v_m1;
            v_m3 <= v_m2;
            v_m4 <= v_m3;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_m1 <= a_d * cs[0];
        pb_m1 <= b_d * sn[0];
        pc_m1 <= c_d * sn[1];
        cx_m1 <= cs[0];
        cy_m1 <= cs[1];

        q0_m2 <= 32'(pteb_pkg::rnd_shift(68'(pa_m1), 30));
        q1_m2 <= 32'(pteb_pkg::rnd_shift(68'(pb_m1), 30));
        q2_m2 <= 32'(pteb_pkg::rnd_shift(68'(pc_m1), 30));
        cx_m2 <= cx_m1;
        cy_m2 <= cy_m1;

        r0_m3 <= q0_m2 * cy_m2;
        r1_m3 <= q1_m2 * cy_m2;
        r2_m3 <= q2_m2 * cx_m2;

        rv_reg[0][0] <= 32'(pteb_pkg::rnd_shift(68'(r0_m3), 30));
        rv_reg[0][1] <= 32'(pteb_pkg::rnd_shift(68'(r1_m3), 30));
        rv_reg[0][2] <= -32'(pteb_pkg::rnd_shift(68'(r2_m3), 30));
    end

    // ---------------- five rotations, two stages each ----------------
    logic vrv_reg [6];
    assign vrv_reg[0] = v_m4;

    for (genvar k = 0; k < 5; k++)
    begin : gen_rot
        logic [63:0]        sc_d;
        pteb_pkg::q30_t     s_d, c_d_rot;
        logic signed [63:0] cp_reg, sq_reg, sp_reg, cq_reg;
        logic signed [31:0] keep_reg;
        logic               vp_reg, vs_reg;
        logic signed [67:0] np_sum, nq_sum;

        pteb_delay #(.W(64), .DEPTH(4 + 2 * k)) u_dly_sc (
            .clk   (clk),
            .rst_n (rst_n),
            .d     ({sn[ROT_ANGLE[k]], cs[ROT_ANGLE[k]]}),
            .q     (sc_d)
        );

        assign s_d     = $signed(sc_d[63:32]);
        assign c_d_rot = $signed(sc_d[31:0]);

        always_ff @(posedge clk)
        begin
            cp_reg   <= c_d_rot * rv_reg[k][ROT_P[k]];
            sq_reg   <= s_d * rv_reg[k][ROT_Q[k]];
            sp_reg   <= s_d * rv_reg[k][ROT_P[k]];
            cq_reg   <= c_d_rot * rv_reg[k][ROT_Q[k]];
            keep_reg <= rv_reg[k][ROT_O[k]];
        end

        always_comb
        begin
            np_sum = 68'(cp_reg) - 68'(sq_reg);
            nq_sum = 68'(sp_reg) + 68'(cq_reg);
        end

        always_ff @(posedge clk)
        begin
            rv_reg[k+1][ROT_P[k]] <= 32'(pteb_pkg::rnd_shift(np_sum, 30));
            rv_reg[k+1][ROT_Q[k]] <= 32'(pteb_pkg::rnd_shift(nq_sum, 30));
            rv_reg[k+1][ROT_O[k]] <= keep_reg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vp_reg <= 1'b0;
                vs_reg <= 1'b0;
            end
            else
            begin
                vp_reg <= vrv_reg[k];
                vs_reg <= vp_reg;
            end
        end

        assign vrv_reg[k+1] = vs_reg;
    end

    // ---------------- yaw: atan2(e.y, e.x) ----------------
    pteb_pkg::turn_t    yaw_turn;
    logic signed [35:0] mag1;
    logic [31:0]        v2_d;
    logic               v_a1;

    pteb_atan2 #(.STAGES(L), .IW(34)) u_atan_yaw (
        .clk      (clk),
        .x_in     (34'(rv_reg[5][0])),
        .y_in     (34'(rv_reg[5][1])),
        .turn_out (yaw_turn),
        .mag_out  (mag1)
    );

    pteb_delay #(.W(32), .DEPTH(L + 1)) u_dly_v2 (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (rv_reg[5][2]),
        .q     (v2_d)
    );

    pteb_delay #(.W(1), .DEPTH(L + 1)) u_dly_va1 (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (vrv_reg[5]),
        .q     (v_a1)
    );

    // remove the CORDIC gain from the horizontal magnitude
    logic               v_q1, v_q2;
    logic signed [65:0] magp_q1;
    logic signed [33:0] nv2_q1, nv2_q2, rxy_q2;
    pteb_pkg::turn_t    yaw_q1, yaw_q2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_q1 <= 1'b0;
            v_q2 <= 1'b0;
        end
        else
        begin
            v_q1 <= v_a1;
            v_q2 <= v_q1;
        end
    end

    always_ff @(posedge clk)
    begin
        magp_q1 <= mag1[33:0] * pteb_pkg::INV_GAIN;
        nv2_q1  <= -34'($signed(v2_d));
        yaw_q1  <= yaw_turn;

        rxy_q2  <= 34'(pteb_pkg::rnd_shift(68'(magp_q1), 30));
        nv2_q2  <= nv2_q1;
        yaw_q2  <= yaw_q1;
    end

    // ---------------- pitch: atan2(-e.z, |e.xy|) ----------------
    pteb_pkg::turn_t    pitch_turn, yaw_a2;
    logic signed [35:0] mag2;
    logic               v_a2;

    pteb_atan2 #(.STAGES(L), .IW(34)) u_atan_pitch (
        .clk      (clk),
        .x_in     (rxy_q2),
        .y_in     (nv2_q2),
        .turn_out (pitch_turn),
        .mag_out  (mag2)
    );

    pteb_delay #(.W(33), .DEPTH(L + 1)) u_dly_yaw (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({v_q2, yaw_q2}),
        .q     ({v_a2, yaw_a2})
    );

    // ---------------- turns to centidegrees ----------------
    logic               v_c1, done_reg;
    logic signed [48:0] ycd_c1, pcd_c1;
    logic signed [15:0] yaw_reg, pitch_reg;
    logic signed [16:0] ycd_r, pcd_r;

    always_comb
    begin
        ycd_r = 17'(pteb_pkg::rnd_shift(68'(ycd_c1), 32));
        pcd_r = 17'(pteb_pkg::rnd_shift(68'(pcd_c1), 32));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c1     <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_c1     <= v_a2;
            done_reg <= v_c1;
        end
    end

    always_ff @(posedge clk)
    begin
        ycd_c1 <= $signed(yaw_a2) * pteb_pkg::CD_PER_TURN;
        pcd_c1 <= $signed(pitch_turn) * pteb_pkg::CD_PER_TURN;
        // minus half a turn reports as plus half a turn
        yaw_reg   <= (ycd_r <= -pteb_pkg::CD_HALF) ? 16'(pteb_pkg::CD_HALF) : ycd_r[15:0];
        pitch_reg <= (pcd_r <= -pteb_pkg::CD_HALF) ? 16'(pteb_pkg::CD_HALF) : pcd_r[15:0];
    end

    assign done          = done_reg;
    assign bearing_yaw   = yaw_reg;
    assign bearing_pitch = pitch_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for pixel_to_earth_bearing_top: bit-exact bearing predictor with a scoreboard
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY   = 3 * 16 + 23;
    localparam int SETTLE    = LATENCY + 10;
    localparam int IDLE_STOP = 3000;

    typedef struct {
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic signed [15:0] g_roll;
        logic signed [15:0] g_pitch;
        logic signed [15:0] g_yaw;
        logic signed [15:0] v_roll;
        logic signed [15:0] v_pitch;
    } detection_t;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } bearing_t;

    class bearing_scoreboard;
        bit [31:0] width_px = 360;
        bit [31:0] height_px = 360;
        bit [31:0] fov_x = 6000;
        bit [31:0] fov_y = 6000;
        bearing_t  pending_bearings[$];
        int        errors = 0;

        static bit [31:0] ATAN_T[16] = '{
            32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

        function void set_reg(pteb_pkg::reg_idx_t idx, bit [31:0] value);
            case (idx)
                pteb_pkg::REG_FRAME_W: width_px  = value & 32'h1FFF;
                pteb_pkg::REG_FRAME_H: height_px = value & 32'h1FFF;
                pteb_pkg::REG_FOV_X:   fov_x     = value & 32'h3FFF;
                pteb_pkg::REG_FOV_Y:   fov_y     = value & 32'h3FFF;
                default: ;
            endcase
        endfunction

        static function longint round_shift(longint p, int k);
            bit neg;
            longint unsigned m;
            neg = p < 0;
            m = neg ? longint'(-p) : p;
            m = (m + (64'd1 << (k - 1))) >> k;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        static function bit [31:0] angle_to_turns(longint v, longint full);
            bit neg;
            longint unsigned m;
            neg = v < 0;
            m = neg ? -v : v;
            m = ((m << 32) + longint'(full / 2)) / full;
            return neg ? 32'(-m) : 32'(m);
        endfunction

        static function longint turns_s(bit [31:0] z);
            return longint'($signed(z));
        endfunction

        static function longint turns_to_cd(bit [31:0] z);
            longint r;
            r = round_shift(turns_s(z) * 36000, 32);
            if (r <= -18000)
                r = 18000;
            return r;
        endfunction

        static function void sin_cos(bit [31:0] ang, output longint s, output longint c);
            bit [31:0] t;
            bit flip;
            longint x, y, z, dx, dy;
            t = ang + pteb_pkg::QUARTER_TURN;
            flip = t[31];
            x = pteb_pkg::INV_GAIN;
            y = 0;
            if (flip)
                ang = ang - pteb_pkg::HALF_TURN;
            z = turns_s(ang);
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= ATAN_T[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ATAN_T[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        static function bit [31:0] vec_angle(longint x, longint y, output longint mag);
            bit [31:0] z;
            longint dx, dy;
            z = 0;
            mag = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                x = -x; y = -y; z = pteb_pkg::HALF_TURN;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z = z + ATAN_T[i];
                end
                else
                begin
                    x -= dx; y += dy; z = z - ATAN_T[i];
                end
            end
            mag = x;
            return z;
        endfunction

        static function void rotate(inout longint p, inout longint q, input bit [31:0] ang);
            longint s, c, np, nq;
            sin_cos(ang, s, c);
            np = round_shift(c * p - s * q, 30);
            nq = round_shift(s * p + c * q, 30);
            p = np;
            q = nq;
        endfunction

        static function longint clampi(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function bearing_t predict_bearing(detection_t d);
            longint w, h, fx, fy, x, y, sx, cx, sy, cy, a, b, c, scale;
            longint v0, v1, v2, mag, rxy;
            bit [31:0] yaw_t, pitch_t;
            bearing_t r;
            w  = clampi(width_px, 100, 8000);
            h  = clampi(height_px, 100, 8000);
            fx = clampi(fov_x, 1000, 15000);
            fy = clampi(fov_y, 1000, 15000);
            x  = clampi(longint'(d.px), -w, w);
            y  = clampi(longint'(d.py), -h, h);
            sin_cos(angle_to_turns(fx, 72000), sx, cx);
            sin_cos(angle_to_turns(fy, 72000), sy, cy);
            a = w * h;
            b = 2 * x * h;
            c = 2 * y * w;
            scale = 1;
            while (a * scale < (64'sd1 <<< 28))
                scale *= 2;
            a *= scale; b *= scale; c *= scale;
            v0 = round_shift(round_shift(a * cx, 30) * cy, 30);
            v1 = round_shift(round_shift(b * sx, 30) * cy, 30);
            v2 = -round_shift(round_shift(c * sy, 30) * cx, 30);
            rotate(v1, v2, angle_to_turns(longint'(d.g_roll), 36000));
            rotate(v2, v0, angle_to_turns(longint'(d.g_pitch), 36000));
            rotate(v0, v1, angle_to_turns(longint'(d.g_yaw), 36000));
            rotate(v2, v0, 32'd0 - angle_to_turns(longint'(d.v_pitch), 36000));
            rotate(v1, v2, 32'd0 - angle_to_turns(longint'(d.v_roll), 36000));
            yaw_t = vec_angle(v0, v1, mag);
            rxy = round_shift(mag * pteb_pkg::INV_GAIN, 30);
            pitch_t = vec_angle(rxy, -v2, mag);
            r.yaw   = 16'(turns_to_cd(yaw_t));
            r.pitch = 16'(turns_to_cd(pitch_t));
            return r;
        endfunction

        function void note_detection(detection_t d);
            pending_bearings.push_back(predict_bearing(d));
        endfunction

        function void check_bearing(logic signed [15:0] yaw, logic signed [15:0] pitch);
            bearing_t e;
            if (pending_bearings.size() == 0)
            begin
                $display("%t unexpected result yaw %0d pitch %0d", $time, yaw, pitch);
                errors++;
                return;
            end
            e = pending_bearings.pop_front();
            if (yaw !== e.yaw)
            begin
                $display("%t bearing_yaw expected %0d actual %0d", $time, e.yaw, yaw);
                errors++;
            end
            if (pitch !== e.pitch)
            begin
                $display("%t bearing_pitch expected %0d actual %0d", $time, e.pitch, pitch);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [13:0] pix_x = '0;
    logic signed [13:0] pix_y = '0;
    logic signed [15:0] gimbal_roll = '0;
    logic signed [15:0] gimbal_pitch = '0;
    logic signed [15:0] gimbal_yaw = '0;
    logic signed [15:0] vehicle_roll = '0;
    logic signed [15:0] vehicle_pitch = '0;
    logic done;
    logic signed [15:0] bearing_yaw;
    logic signed [15:0] bearing_pitch;

    bearing_scoreboard sb = new();
    int idle_cycles = 0;
    bit burst_mode = 0;

    pixel_to_earth_bearing_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .pix_x(pix_x), .pix_y(pix_y),
        .gimbal_roll(gimbal_roll), .gimbal_pitch(gimbal_pitch), .gimbal_yaw(gimbal_yaw),
        .vehicle_roll(vehicle_roll), .vehicle_pitch(vehicle_pitch),
        .done(done), .bearing_yaw(bearing_yaw), .bearing_pitch(bearing_pitch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // outputs change at rising edges only, so the falling edge sees stable values
    always @(negedge clk)
    begin
        detection_t d;
        bit active;
        active = 0;
        if (rst_n && start && !busy)
        begin
            d = '{pix_x, pix_y, gimbal_roll, gimbal_pitch, gimbal_yaw,
                  vehicle_roll, vehicle_pitch};
            sb.note_detection(d);
            active = 1;
        end
        if (rst_n && done)
        begin
            sb.check_bearing(bearing_yaw, bearing_pitch);
            active = 1;
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_STOP)
        begin
            $display("[pixel_to_earth_bearing_top] ERROR");
            $finish;
        end
    end

    task automatic apb_write(pteb_pkg::reg_idx_t idx, bit [31:0] value);
        bit rdy;
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_detection(detection_t d);
        bit b;
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pix_x <= d.px; pix_y <= d.py;
        gimbal_roll <= d.g_roll; gimbal_pitch <= d.g_pitch; gimbal_yaw <= d.g_yaw;
        vehicle_roll <= d.v_roll; vehicle_pitch <= d.v_pitch;
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end
        while (b);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (sb.pending_bearings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(bit [31:0] w, bit [31:0] h, bit [31:0] fx, bit [31:0] fy);
        apb_write(pteb_pkg::REG_FRAME_W, w);
        apb_write(pteb_pkg::REG_FRAME_H, h);
        apb_write(pteb_pkg::REG_FOV_X, fx);
        apb_write(pteb_pkg::REG_FOV_Y, fy);
    endtask

    function automatic logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 16'($urandom);
        if (r < 4)
            return 16'($signed($urandom_range(0, 2000)) - 1000);
        return 16'($signed($urandom_range(0, 36000)) - 18000);
    endfunction

    function automatic logic signed [13:0] rand_offset(int lim);
        if ($urandom_range(0, 4) == 0)
            return 14'($urandom);
        if (lim > 8000)
            lim = 8000;
        if (lim < 100)
            lim = 100;
        return 14'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    task automatic random_phase(int n);
        detection_t d;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                burst_mode = $urandom_range(0, 2) == 0;
            d.px = rand_offset(sb.width_px);
            d.py = rand_offset(sb.height_px);
            d.g_roll = rand_angle();
            d.g_pitch = rand_angle();
            d.g_yaw = rand_angle();
            d.v_roll = rand_angle();
            d.v_pitch = rand_angle();
            send_detection(d);
        end
        burst_mode = 0;
    endtask

    initial
    begin
        detection_t directed[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, saturation, angle wrap, straight-up view, yaw at -180
        directed = '{
            '{0, 0, 0, 0, 0, 0, 0},
            '{180, 180, 0, 0, 0, 0, 0},
            '{-180, -180, 0, 0, 0, 0, 0},
            '{8191, -8192, 0, 0, 0, 0, 0},
            '{-8000, 8000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, -18000, 0, 0},
            '{0, 0, 0, 0, 18000, 0, 0},
            '{0, 0, 0, 9000, 0, 0, 0},
            '{0, 0, 0, -9000, 0, 0, 0},
            '{0, 0, 18000, -18000, 0, 18000, -18000},
            '{0, 0, 32767, -32768, 32767, -32768, 32767},
            '{0, 0, -32768, 32767, -32768, 32767, -32768},
            '{100, -50, 4500, 0, 0, 0, 0},
            '{-100, 50, 0, 0, 0, -4500, 0},
            '{30, 90, 0, 0, 0, 0, 9000},
            '{-5, 7, 1234, -2345, 17999, -17999, 1},
            '{0, 0, 0, 0, 0, 0, 9000},
            '{-8192, 8191, -1, 1, -1, 1, -1}
        };
        foreach (directed[k])
            send_detection(directed[k]);
        random_phase(150);
        drain_pipeline();

        configure(100, 100, 1000, 1000);
        random_phase(250);
        drain_pipeline();

        configure(8000, 8000, 15000, 15000);
        random_phase(250);
        drain_pipeline();

        // out-of-range values exercise the clamps
        configure(0, 8191, 16383, 0);
        random_phase(250);
        drain_pipeline();

        configure(640, 480, 9000, 6750);
        random_phase(300);
        drain_pipeline();

        configure($urandom_range(100, 8000), $urandom_range(100, 8000),
                  $urandom_range(1000, 15000), $urandom_range(1000, 15000));
        random_phase(330);
        drain_pipeline();

        if (sb.errors == 0)
            $display("[pixel_to_earth_bearing_top] OK");
        else
            $display("[pixel_to_earth_bearing_top] ERROR");
        $finish;
    end
endmodule
